### rtl/core/nps_pkg.sv
// ----------------------------------------------------------------------------
// nps_pkg
// Shared widths, the job entry layout and control types of the scheduler.
// ----------------------------------------------------------------------------
package nps_pkg;

    localparam int TABLE_DEPTH_DEF = 16;

    localparam int ARRIVAL_W = 32;
    localparam int PRIO_W    = 8;
    localparam int LEN_W     = 16;
    localparam int PENDING_W = 5;

    localparam logic [ARRIVAL_W-1:0] TICK_MAX = '1;

    localparam logic ACTION_ADD  = 1'b0;
    localparam logic ACTION_TICK = 1'b1;

    typedef struct packed {
        logic [ARRIVAL_W-1:0] arrival;
        logic [PRIO_W-1:0]    prio;
        logic [LEN_W-1:0]     len;
    } job_entry_t;

    typedef struct packed {
        logic clear;
        logic eval;
    } select_ctrl_t;

endpackage

### rtl/core/nps_job_mem.sv
// ----------------------------------------------------------------------------
// nps_job_mem
// Job table storage: one write port and one registered read port.
// ----------------------------------------------------------------------------
module nps_job_mem
    import nps_pkg::*;
#(
    parameter int DEPTH = TABLE_DEPTH_DEF,
    parameter int IDX_W = $clog2(DEPTH)
)
(
    input  logic             clk,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_addr,
    input  job_entry_t       wr_data,
    input  logic [IDX_W-1:0] rd_addr,
    output job_entry_t       rd_data
);

    job_entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

### rtl/core/nps_select.sv
// ----------------------------------------------------------------------------
// nps_select
// Shared compare unit that keeps the best eligible job seen during a scan.
// ----------------------------------------------------------------------------
module nps_select
    import nps_pkg::*;
#(
    parameter int DEPTH = TABLE_DEPTH_DEF,
    parameter int IDX_W = $clog2(DEPTH)
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  select_ctrl_t         ctrl,
    input  logic [IDX_W-1:0]     idx,
    input  job_entry_t           entry,
    input  logic [ARRIVAL_W-1:0] tick,
    output logic                 found,
    output logic [IDX_W-1:0]     best_idx,
    output job_entry_t           best
);

    logic             found_reg, found_next;
    logic [IDX_W-1:0] best_idx_reg, best_idx_next;
    job_entry_t       best_reg, best_next;
    logic             better;

    // Strict less-than keeps the earliest inserted job on a priority tie.
    assign better = (entry.arrival <= tick) && (!found_reg || (entry.prio < best_reg.prio));

    always_comb
    begin
        found_next    = found_reg;
        best_idx_next = best_idx_reg;
        best_next     = best_reg;
        if (ctrl.clear)
        begin
            found_next = 1'b0;
        end
        else if (ctrl.eval && better)
        begin
            found_next    = 1'b1;
            best_idx_next = idx;
            best_next     = entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else
        begin
            found_reg <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        best_idx_reg <= best_idx_next;
        best_reg     <= best_next;
    end

    assign found    = found_reg;
    assign best_idx = best_idx_reg;
    assign best     = best_reg;

endmodule

### rtl/core/nonpreemptive_priority_scheduler_core.sv
// ----------------------------------------------------------------------------
// nonpreemptive_priority_scheduler_core
// An add, or a tick with a job running or an empty table, goes straight to
// FINISH. A tick with the CPU idle and jobs pending scans the table in SCAN,
// compacts it in MOVE if a job is found, then goes to FINISH, which waits
// while a held result is stalled and then registers the result. One item at
// a time. Reset clears the job count, tick counter and countdown and sets idle.
// ----------------------------------------------------------------------------
module nonpreemptive_priority_scheduler_core
    import nps_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 item_valid,
    output logic                 item_stall,
    input  logic                 action,
    input  logic [ARRIVAL_W-1:0] arrival_tick,
    input  logic [PRIO_W-1:0]    job_priority,
    input  logic [LEN_W-1:0]     run_length,

    output logic                 result_valid,
    input  logic                 result_stall,
    output logic                 add_rejected,
    output logic                 dispatched,
    output logic [PRIO_W-1:0]    dispatched_priority,
    output logic [ARRIVAL_W-1:0] dispatched_arrival,
    output logic                 cpu_busy,
    output logic [LEN_W-1:0]     time_left,
    output logic [ARRIVAL_W-1:0] tick_now,
    output logic [PENDING_W-1:0] pending_jobs
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_MOVE   = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    logic [1:0]           state_reg, state_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [ARRIVAL_W-1:0] tick_reg, tick_next;
    logic [LEN_W-1:0]     active_reg, active_next;
    logic                 idle_reg, idle_next;
    logic [CNT_W-1:0]     ptr_reg, ptr_next;
    logic                 lag_valid_reg, lag_valid_next;
    logic [IDX_W-1:0]     lag_idx_reg, lag_idx_next;
    logic                 op_tick_reg, op_tick_next;
    logic                 reject_reg, reject_next;
    logic                 run_reg, run_next;
    logic                 disp_reg, disp_next;

    logic                 result_valid_reg, result_valid_next;
    logic                 res_rej_reg, res_rej_next;
    logic                 res_disp_reg, res_disp_next;
    logic [PRIO_W-1:0]    res_prio_reg, res_prio_next;
    logic [ARRIVAL_W-1:0] res_arr_reg, res_arr_next;
    logic                 res_busy_reg, res_busy_next;
    logic [LEN_W-1:0]     res_left_reg, res_left_next;
    logic [ARRIVAL_W-1:0] res_tick_reg, res_tick_next;
    logic [PENDING_W-1:0] res_pend_reg, res_pend_next;

    logic                 accept;
    logic                 wr_en;
    logic [IDX_W-1:0]     wr_addr;
    job_entry_t           wr_data;
    logic [IDX_W-1:0]     rd_addr;
    job_entry_t           rd_data;

    select_ctrl_t         sel_ctrl;
    logic                 sel_found;
    logic [IDX_W-1:0]     sel_idx;
    job_entry_t           sel_best;

    assign item_stall = (state_reg != ST_IDLE);
    assign accept     = item_valid && !item_stall;

    nps_job_mem #(
        .DEPTH (TABLE_DEPTH),
        .IDX_W (IDX_W)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    nps_select #(
        .DEPTH (TABLE_DEPTH),
        .IDX_W (IDX_W)
    ) u_select (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (sel_ctrl),
        .idx      (lag_idx_reg),
        .entry    (rd_data),
        .tick     (tick_reg),
        .found    (sel_found),
        .best_idx (sel_idx),
        .best     (sel_best)
    );

    always_comb
    begin
        logic [LEN_W-1:0]     act_n;
        logic                 idle_n;
        logic [ARRIVAL_W-1:0] tick_n;

        state_next        = state_reg;
        count_next        = count_reg;
        tick_next         = tick_reg;
        active_next       = active_reg;
        idle_next         = idle_reg;
        ptr_next          = ptr_reg;
        lag_valid_next    = 1'b0;
        lag_idx_next      = lag_idx_reg;
        op_tick_next      = op_tick_reg;
        reject_next       = reject_reg;
        run_next          = run_reg;
        disp_next         = disp_reg;

        result_valid_next = result_valid_reg && result_stall;
        res_rej_next      = res_rej_reg;
        res_disp_next     = res_disp_reg;
        res_prio_next     = res_prio_reg;
        res_arr_next      = res_arr_reg;
        res_busy_next     = res_busy_reg;
        res_left_next     = res_left_reg;
        res_tick_next     = res_tick_reg;
        res_pend_next     = res_pend_reg;

        wr_en             = 1'b0;
        wr_addr           = count_reg[IDX_W-1:0];
        wr_data.arrival   = arrival_tick;
        wr_data.prio      = job_priority;
        wr_data.len       = run_length;
        rd_addr           = ptr_reg[IDX_W-1:0];
        sel_ctrl.clear    = 1'b0;
        sel_ctrl.eval     = 1'b0;

        act_n             = active_reg;
        idle_n            = idle_reg;
        tick_n            = tick_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    op_tick_next = (action == ACTION_TICK);
                    reject_next  = 1'b0;
                    run_next     = 1'b0;
                    disp_next    = 1'b0;
                    state_next   = ST_FINISH;
                    if (action == ACTION_ADD)
                    begin
                        if (count_reg >= DEPTH_CNT)
                        begin
                            reject_next = 1'b1;
                        end
                        else
                        begin
                            wr_en      = 1'b1;
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                    else if (!idle_reg)
                    begin
                        run_next = 1'b1;
                    end
                    else if (count_reg != '0)
                    begin
                        sel_ctrl.clear = 1'b1;
                        ptr_next       = '0;
                        state_next     = ST_SCAN;
                    end
                end
            end

            ST_SCAN:
            begin
                // The read port is registered; lag_valid_reg and lag_idx_reg follow the read address into the compare.
                sel_ctrl.eval = lag_valid_reg;
                if (ptr_reg < count_reg)
                begin
                    ptr_next       = ptr_reg + CNT_W'(1);
                    lag_valid_next = 1'b1;
                    lag_idx_next   = ptr_reg[IDX_W-1:0];
                end
                else if (!lag_valid_reg)
                begin
                    if (sel_found)
                    begin
                        ptr_next   = CNT_W'(sel_idx) + CNT_W'(1);
                        state_next = ST_MOVE;
                    end
                    else
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end

            ST_MOVE:
            begin
                // Each entry above the winner moves down one slot.
                if (lag_valid_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = lag_idx_reg - IDX_W'(1);
                    wr_data = rd_data;
                end
                if (ptr_reg < count_reg)
                begin
                    ptr_next       = ptr_reg + CNT_W'(1);
                    lag_valid_next = 1'b1;
                    lag_idx_next   = ptr_reg[IDX_W-1:0];
                end
                else if (!lag_valid_reg)
                begin
                    count_next  = count_reg - CNT_W'(1);
                    active_next = sel_best.len;
                    run_next    = 1'b1;
                    disp_next   = 1'b1;
                    state_next  = ST_FINISH;
                end
            end

            ST_FINISH:
            begin
                if (!result_valid_reg || !result_stall)
                begin
                    if (op_tick_reg)
                    begin
                        if (run_reg)
                        begin
                            act_n  = (active_reg != '0) ? active_reg - LEN_W'(1) : '0;
                            idle_n = (act_n == '0);
                        end
                        tick_n = (tick_reg != TICK_MAX) ? tick_reg + ARRIVAL_W'(1) : tick_reg;
                    end
                    active_next       = act_n;
                    idle_next         = idle_n;
                    tick_next         = tick_n;
                    result_valid_next = 1'b1;
                    res_rej_next      = reject_reg;
                    res_disp_next     = disp_reg;
                    res_prio_next     = disp_reg ? sel_best.prio : '0;
                    res_arr_next      = disp_reg ? sel_best.arrival : '0;
                    res_busy_next     = !idle_n;
                    res_left_next     = act_n;
                    res_tick_next     = tick_n;
                    res_pend_next     = PENDING_W'(count_reg);
                    state_next        = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            count_reg        <= '0;
            tick_reg         <= '0;
            active_reg       <= '0;
            idle_reg         <= 1'b1;
            lag_valid_reg    <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            count_reg        <= count_next;
            tick_reg         <= tick_next;
            active_reg       <= active_next;
            idle_reg         <= idle_next;
            lag_valid_reg    <= lag_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg      <= ptr_next;
        lag_idx_reg  <= lag_idx_next;
        op_tick_reg  <= op_tick_next;
        reject_reg   <= reject_next;
        run_reg      <= run_next;
        disp_reg     <= disp_next;
        res_rej_reg  <= res_rej_next;
        res_disp_reg <= res_disp_next;
        res_prio_reg <= res_prio_next;
        res_arr_reg  <= res_arr_next;
        res_busy_reg <= res_busy_next;
        res_left_reg <= res_left_next;
        res_tick_reg <= res_tick_next;
        res_pend_reg <= res_pend_next;
    end

    assign result_valid        = result_valid_reg;
    assign add_rejected        = res_rej_reg;
    assign dispatched          = res_disp_reg;
    assign dispatched_priority = res_prio_reg;
    assign dispatched_arrival  = res_arr_reg;
    assign cpu_busy            = res_busy_reg;
    assign time_left           = res_left_reg;
    assign tick_now            = res_tick_reg;
    assign pending_jobs        = res_pend_reg;

endmodule

### bench/nps_schedule_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nps_schedule_checker
// Watches the item and result channels of the scheduler core. It keeps its
// own job table, tick counter and countdown, predicts the result of every
// accepted item and compares each accepted result field by field.
// ----------------------------------------------------------------------------
module nps_schedule_checker
    import nps_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 item_valid,
    input  logic                 item_stall,
    input  logic                 action,
    input  logic [ARRIVAL_W-1:0] arrival_tick,
    input  logic [PRIO_W-1:0]    job_priority,
    input  logic [LEN_W-1:0]     run_length,

    input  logic                 result_valid,
    input  logic                 result_stall,
    input  logic                 add_rejected,
    input  logic                 dispatched,
    input  logic [PRIO_W-1:0]    dispatched_priority,
    input  logic [ARRIVAL_W-1:0] dispatched_arrival,
    input  logic                 cpu_busy,
    input  logic [LEN_W-1:0]     time_left,
    input  logic [ARRIVAL_W-1:0] tick_now,
    input  logic [PENDING_W-1:0] pending_jobs,

    output int                   fail_count,
    output int                   expected_left
);

    localparam int DEPTH = TABLE_DEPTH_DEF;

    typedef struct packed {
        logic                 add_rejected;
        logic                 dispatched;
        logic [PRIO_W-1:0]    prio;
        logic [ARRIVAL_W-1:0] arrival;
        logic                 busy;
        logic [LEN_W-1:0]     time_left;
        logic [ARRIVAL_W-1:0] tick_now;
        logic [PENDING_W-1:0] pending;
    } sched_result_t;

    job_entry_t           jobs [DEPTH];
    int                   job_total;
    logic [ARRIVAL_W-1:0] tick_count;
    logic [LEN_W-1:0]     remaining;
    logic                 cpu_idle;

    sched_result_t        outcome_q [$];
    sched_result_t        predicted;
    sched_result_t        wanted;

    task automatic schedule_step(
        input  logic                 act,
        input  logic [ARRIVAL_W-1:0] new_arrival,
        input  logic [PRIO_W-1:0]    new_prio,
        input  logic [LEN_W-1:0]     new_len,
        output sched_result_t        res
    );
        int best;
        bit found;
        bit runs;
        res = '0;
        if (act == ACTION_ADD)
        begin
            if (job_total >= DEPTH)
                res.add_rejected = 1'b1;
            else
            begin
                jobs[job_total] = '{arrival: new_arrival, prio: new_prio, len: new_len};
                job_total++;
            end
        end
        else
        begin
            runs  = !cpu_idle;
            found = 1'b0;
            best  = 0;
            if (cpu_idle)
            begin
                // Strict less-than keeps the earliest inserted job on a tie.
                for (int k = 0; k < job_total; k++)
                begin
                    if (jobs[k].arrival <= tick_count &&
                        (!found || jobs[k].prio < jobs[best].prio))
                    begin
                        found = 1'b1;
                        best  = k;
                    end
                end
                if (found)
                begin
                    res.dispatched = 1'b1;
                    res.prio       = jobs[best].prio;
                    res.arrival    = jobs[best].arrival;
                    remaining      = jobs[best].len;
                    for (int k = best; k + 1 < job_total; k++)
                        jobs[k] = jobs[k + 1];
                    job_total--;
                    runs = 1'b1;
                end
            end
            if (runs)
            begin
                if (remaining != '0)
                    remaining--;
                cpu_idle = (remaining == '0);
            end
            if (tick_count != TICK_MAX)
                tick_count++;
        end
        res.busy      = !cpu_idle;
        res.time_left = remaining;
        res.tick_now  = tick_count;
        res.pending   = job_total[PENDING_W-1:0];
    endtask

    task automatic check_field(input string what, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want)
        begin
            fail_count++;
            $display("%0t: %s mismatch, expected %0h, actual %0h",
                     $time, what, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_total  = 0;
            tick_count = '0;
            remaining  = '0;
            cpu_idle   = 1'b1;
            outcome_q.delete();
            expected_left = 0;
        end
        else
        begin
            if (item_valid && !item_stall)
            begin
                schedule_step(action, arrival_tick, job_priority, run_length, predicted);
                outcome_q.insert(outcome_q.size(), predicted);
            end
            if (result_valid && !result_stall)
            begin
                if (outcome_q.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected result, expected none, actual tick_now %0h",
                             $time, tick_now);
                end
                else
                begin
                    wanted = outcome_q.pop_front();
                    check_field("add_rejected", 64'(wanted.add_rejected),
                                64'(add_rejected));
                    check_field("dispatched", 64'(wanted.dispatched), 64'(dispatched));
                    check_field("dispatched_priority", 64'(wanted.prio),
                                64'(dispatched_priority));
                    check_field("dispatched_arrival", 64'(wanted.arrival),
                                64'(dispatched_arrival));
                    check_field("cpu_busy", 64'(wanted.busy), 64'(cpu_busy));
                    check_field("time_left", 64'(wanted.time_left), 64'(time_left));
                    check_field("tick_now", 64'(wanted.tick_now), 64'(tick_now));
                    check_field("pending_jobs", 64'(wanted.pending), 64'(pending_jobs));
                end
            end
            expected_left = outcome_q.size();
        end
    end

endmodule

### bench/nonpreemptive_priority_scheduler_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nonpreemptive_priority_scheduler_core_tb
// Drives adds and ticks into the scheduler core: a directed opening that
// covers field extremes, ties, idle ticks and a full table, then random
// traffic with random gaps and result back-pressure. The checker beside the
// core predicts and compares every result; this module gives the verdict.
// ----------------------------------------------------------------------------
module nonpreemptive_priority_scheduler_core_tb;
    import nps_pkg::*;

    localparam int RANDOM_ITEMS = 400;
    localparam int CALM_FIRST   = 100;
    localparam int CALM_LAST    = 180;
    localparam int HOLD_START   = 300;
    localparam int HOLD_CYCLES  = 200;
    localparam int QUIET_START  = 800;
    localparam int QUIET_END    = 1600;
    localparam int DRAIN_CYCLES = 2 * TABLE_DEPTH_DEF + 8;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 item_valid;
    logic                 item_stall;
    logic                 action;
    logic [ARRIVAL_W-1:0] arrival_tick;
    logic [PRIO_W-1:0]    job_priority;
    logic [LEN_W-1:0]     run_length;
    logic                 result_valid;
    logic                 result_stall;
    logic                 add_rejected;
    logic                 dispatched;
    logic [PRIO_W-1:0]    dispatched_priority;
    logic [ARRIVAL_W-1:0] dispatched_arrival;
    logic                 cpu_busy;
    logic [LEN_W-1:0]     time_left;
    logic [ARRIVAL_W-1:0] tick_now;
    logic [PENDING_W-1:0] pending_jobs;

    int fail_count;
    int expected_left;
    int ticks_sent;
    int rx_cycle;

    nonpreemptive_priority_scheduler_core u_top (
        .clk                 (clk),
        .rst_n               (rst_n),
        .item_valid          (item_valid),
        .item_stall          (item_stall),
        .action              (action),
        .arrival_tick        (arrival_tick),
        .job_priority        (job_priority),
        .run_length          (run_length),
        .result_valid        (result_valid),
        .result_stall        (result_stall),
        .add_rejected        (add_rejected),
        .dispatched          (dispatched),
        .dispatched_priority (dispatched_priority),
        .dispatched_arrival  (dispatched_arrival),
        .cpu_busy            (cpu_busy),
        .time_left           (time_left),
        .tick_now            (tick_now),
        .pending_jobs        (pending_jobs)
    );

    nps_schedule_checker u_checker (
        .clk                 (clk),
        .rst_n               (rst_n),
        .item_valid          (item_valid),
        .item_stall          (item_stall),
        .action              (action),
        .arrival_tick        (arrival_tick),
        .job_priority        (job_priority),
        .run_length          (run_length),
        .result_valid        (result_valid),
        .result_stall        (result_stall),
        .add_rejected        (add_rejected),
        .dispatched          (dispatched),
        .dispatched_priority (dispatched_priority),
        .dispatched_arrival  (dispatched_arrival),
        .cpu_busy            (cpu_busy),
        .time_left           (time_left),
        .tick_now            (tick_now),
        .pending_jobs        (pending_jobs),
        .fail_count          (fail_count),
        .expected_left       (expected_left)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Offers one item at a falling edge and holds it until it is taken.
    task automatic offer_item(
        input logic                 act,
        input logic [ARRIVAL_W-1:0] arr,
        input logic [PRIO_W-1:0]    pri,
        input logic [LEN_W-1:0]     len,
        input bit                   may_idle
    );
        if (may_idle && $urandom_range(0, 99) < 20)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        action       <= act;
        arrival_tick <= arr;
        job_priority <= pri;
        run_length   <= len;
        item_valid   <= 1'b1;
        do
            @(posedge clk);
        while (item_stall !== 1'b0);
        @(negedge clk);
        if (act == ACTION_TICK)
            ticks_sent++;
    endtask

    // Result side: random stalls, a quiet window, and one long hold that
    // backs the core up until it stalls the item channel.
    initial
    begin
        result_stall = 1'b0;
        rx_cycle     = 0;
        forever
        begin
            @(negedge clk);
            rx_cycle++;
            if (rx_cycle >= HOLD_START && rx_cycle < HOLD_START + HOLD_CYCLES)
                result_stall <= 1'b1;
            else if (rx_cycle >= QUIET_START && rx_cycle < QUIET_END)
                result_stall <= 1'b0;
            else
                result_stall <= ($urandom_range(0, 99) < 20);
        end
    end

    initial
    begin : stimulus
        logic [ARRIVAL_W-1:0] arr;
        logic [PRIO_W-1:0]    pri;
        logic [LEN_W-1:0]     len;
        int                   roll;
        bit                   may_idle;

        rst_n        = 1'b0;
        item_valid   = 1'b0;
        action       = ACTION_ADD;
        arrival_tick = '0;
        job_priority = '0;
        run_length   = '0;
        ticks_sent   = 0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed opening.
        offer_item(ACTION_TICK, '0, '0, '0, 1'b1);
        // A job that never becomes eligible, with every field at its maximum.
        offer_item(ACTION_ADD, '1, '1, '1, 1'b1);
        offer_item(ACTION_TICK, '0, '0, '0, 1'b1);
        // Arrival equal to the tick counter, zero run length.
        offer_item(ACTION_ADD, ARRIVAL_W'(ticks_sent), '0, '0, 1'b1);
        // Two jobs of equal priority: the first inserted must win.
        offer_item(ACTION_ADD, '0, 8'd7, 16'd2, 1'b1);
        offer_item(ACTION_ADD, '0, 8'd7, 16'd1, 1'b1);
        repeat (4) offer_item(ACTION_TICK, '1, '1, '1, 1'b1);
        offer_item(ACTION_ADD, 32'd100, '0, 16'd1, 1'b1);
        // Fill the table; the last add finds it full.
        for (int k = 0; k < 15; k++)
            offer_item(ACTION_ADD, ARRIVAL_W'(k), PRIO_W'($urandom_range(0, 255)),
                       16'd1, 1'b1);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            may_idle = !(n >= CALM_FIRST && n < CALM_LAST);
            roll = $urandom_range(0, 99);
            if (roll < 68)
            begin
                offer_item(ACTION_TICK, $urandom(), PRIO_W'($urandom()),
                           LEN_W'($urandom()), may_idle);
            end
            else
            begin
                roll = $urandom_range(0, 99);
                if (roll < 2)
                    arr = $urandom();
                else
                    arr = $urandom_range(0, ticks_sent + 10);
                if ($urandom_range(0, 99) < 30)
                    pri = PRIO_W'($urandom_range(0, 3));
                else
                    pri = PRIO_W'($urandom_range(0, 255));
                if ($urandom_range(0, 99) < 85)
                    len = LEN_W'($urandom_range(0, 3));
                else
                    len = LEN_W'($urandom_range(4, 30));
                offer_item(ACTION_ADD, arr, pri, len, may_idle);
            end
        end
        item_valid <= 1'b0;

        while (expected_left != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial
    begin
        #3_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

### filelist.f
rtl/core/nps_pkg.sv
rtl/core/nps_job_mem.sv
rtl/core/nps_select.sv
rtl/core/nonpreemptive_priority_scheduler_core.sv
bench/nps_schedule_checker.sv
bench/nonpreemptive_priority_scheduler_core_tb.sv
